// ----- rtl/cpf_pkg.sv -----
`timescale 1ns / 1ps

package cpf_pkg;

  localparam logic [3:0] PLAIN_LEN   = 4'd11;
  localparam logic [3:0] PUNCT_LEN   = 4'd14;
  localparam logic [3:0] COUNT_TOP   = 4'd15;
  localparam logic [1:0] SEP_TOP     = 2'd3;
  localparam logic [1:0] DOTS_NEEDED = 2'd2;
  localparam logic [1:0] HYPH_NEEDED = 2'd1;
  localparam logic [3:0] FIRST_TOP_W = 4'd10;
  localparam logic [3:0] SECOND_TOP_W = 4'd11;
  localparam logic [3:0] FIRST_SPAN  = 4'd9;
  localparam logic [3:0] SECOND_SPAN = 4'd10;
  localparam logic [7:0] ZERO_CODE   = 8'h30;
  localparam logic [7:0] NINE_CODE   = 8'h39;
  localparam logic [7:0] DOT_CODE    = 8'h2E;
  localparam logic [7:0] HYPHEN_CODE = 8'h2D;

  typedef struct packed {
    logic       advance;
    logic       last_char;
    logic [7:0] char_code;
  } step_t;

  // Reduce a value below 110 to its residue mod 11.
  function automatic logic [3:0] fold_mod11(input logic [6:0] v);
    logic [6:0] t;
    t = v;
    if (t >= 7'd88) t = t - 7'd88;
    if (t >= 7'd44) t = t - 7'd44;
    if (t >= 7'd22) t = t - 7'd22;
    if (t >= 7'd11) t = t - 7'd11;
    return t[3:0];
  endfunction

  // (sum * 10) mod 11 is -sum mod 11; a result of 10 maps to 0.
  function automatic logic [3:0] check_digit(input logic [3:0] residue);
    logic [3:0] c;
    if (residue <= 4'd1) c = 4'd0;
    else c = 4'd11 - residue;
    return c;
  endfunction

endpackage

// ----- rtl/cpf_if.sv -----
`timescale 1ns / 1ps

interface cpf_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface cpf_result_if;
  logic valid;
  logic ready;
  logic id_valid;

  modport source (output valid, output id_valid, input ready);
  modport sink (input valid, input id_valid, output ready);
endinterface

// ----- rtl/cpf_digit_acc.sv -----
`timescale 1ns / 1ps

module cpf_digit_acc (
  input  logic           clk,
  input  logic           rst,
  input  cpf_pkg::step_t step,
  output logic           verdict
);

  logic [3:0] char_count, char_count_next;
  logic [3:0] digit_count, digit_count_next;
  logic [1:0] dot_count, dot_count_next;
  logic [1:0] hyphen_count, hyphen_count_next;
  logic       bad_char_seen, bad_char_seen_next;
  logic [3:0] first_res, first_res_next;
  logic [3:0] second_res, second_res_next;
  logic [3:0] tenth_digit, tenth_digit_next;
  logic [3:0] eleventh_digit, eleventh_digit_next;

  logic       is_digit;
  logic [3:0] digit;
  logic [3:0] first_w, second_w;
  logic [7:0] first_prod, second_prod;
  logic       fmt_ok;

  assign is_digit    = (step.char_code >= cpf_pkg::ZERO_CODE) &&
                       (step.char_code <= cpf_pkg::NINE_CODE);
  assign digit       = step.char_code[3:0];
  assign first_w     = cpf_pkg::FIRST_TOP_W - digit_count;
  assign second_w    = cpf_pkg::SECOND_TOP_W - digit_count;
  assign first_prod  = digit * first_w;
  assign second_prod = digit * second_w;

  always_comb begin
    char_count_next     = (char_count == cpf_pkg::COUNT_TOP) ? char_count : char_count + 4'd1;
    digit_count_next    = digit_count;
    dot_count_next      = dot_count;
    hyphen_count_next   = hyphen_count;
    bad_char_seen_next  = bad_char_seen;
    first_res_next      = first_res;
    second_res_next     = second_res;
    tenth_digit_next    = tenth_digit;
    eleventh_digit_next = eleventh_digit;

    priority if (is_digit) begin
      if (digit_count < cpf_pkg::FIRST_SPAN) begin
        first_res_next = cpf_pkg::fold_mod11({3'b000, first_res} + first_prod[6:0]);
      end
      if (digit_count < cpf_pkg::SECOND_SPAN) begin
        second_res_next = cpf_pkg::fold_mod11({3'b000, second_res} + second_prod[6:0]);
      end
      if (digit_count == cpf_pkg::FIRST_SPAN) tenth_digit_next = digit;
      if (digit_count == cpf_pkg::SECOND_SPAN) eleventh_digit_next = digit;
      if (digit_count != cpf_pkg::COUNT_TOP) digit_count_next = digit_count + 4'd1;
    end else if (step.char_code == cpf_pkg::DOT_CODE) begin
      if (dot_count != cpf_pkg::SEP_TOP) dot_count_next = dot_count + 2'd1;
    end else if (step.char_code == cpf_pkg::HYPHEN_CODE) begin
      if (hyphen_count != cpf_pkg::SEP_TOP) hyphen_count_next = hyphen_count + 2'd1;
    end else begin
      bad_char_seen_next = 1'b1;
    end
  end

  always_comb begin
    priority if (bad_char_seen_next) begin
      fmt_ok = 1'b0;
    end else if (char_count_next == cpf_pkg::PLAIN_LEN) begin
      fmt_ok = (digit_count_next == cpf_pkg::PLAIN_LEN);
    end else if (char_count_next == cpf_pkg::PUNCT_LEN) begin
      fmt_ok = (dot_count_next == cpf_pkg::DOTS_NEEDED) &&
               (hyphen_count_next == cpf_pkg::HYPH_NEEDED) &&
               (digit_count_next == cpf_pkg::PLAIN_LEN);
    end else begin
      fmt_ok = 1'b0;
    end
  end

  assign verdict = fmt_ok &&
                   (cpf_pkg::check_digit(first_res_next) == tenth_digit_next) &&
                   (cpf_pkg::check_digit(second_res_next) == eleventh_digit_next);

  always_ff @(posedge clk) begin
    if (rst || (step.advance && step.last_char)) begin
      // start a fresh ID after the verdict
      char_count     <= '0;
      digit_count    <= '0;
      dot_count      <= '0;
      hyphen_count   <= '0;
      bad_char_seen  <= 1'b0;
      first_res      <= '0;
      second_res     <= '0;
      tenth_digit    <= '0;
      eleventh_digit <= '0;
    end else if (step.advance) begin
      char_count     <= char_count_next;
      digit_count    <= digit_count_next;
      dot_count      <= dot_count_next;
      hyphen_count   <= hyphen_count_next;
      bad_char_seen  <= bad_char_seen_next;
      first_res      <= first_res_next;
      second_res     <= second_res_next;
      tenth_digit    <= tenth_digit_next;
      eleventh_digit <= eleventh_digit_next;
    end
  end

endmodule

// ----- rtl/cpf_check_digit_validator.sv -----
`timescale 1ns / 1ps

// CPF check digit validator.
// char_in carries one ASCII character of a taxpayer ID per word, with
// last_char set on the final character. result_out carries one word per ID,
// id_valid = 1 when the ID is 11 digits (or 14 characters with two dots and
// one hyphen) and both mod-11 check digits match.
// Throughput: one character per clock while result_out is not stalled.
// Each character is captured in an input register, then folded into the
// running residues and counters; the verdict is formed as the last character
// leaves the input register and lands in the output register.
// A stalled result_out holds the verdict; characters of the next ID keep
// flowing until its last character reaches the held verdict, then char_in
// drops ready. ready on char_in follows result_out.ready combinationally.
// Reset (synchronous, rst high) empties both registers and clears all
// counters and residues; the first character after reset starts a new ID.
module cpf_check_digit_validator (
  input logic                clk,
  input logic                rst,
  cpf_char_if.sink           char_in,
  cpf_result_if.source       result_out
);

  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;
  logic       s1_advance;
  logic       out_valid;
  logic       id_valid;
  logic       verdict;

  cpf_pkg::step_t step;

  // a non-final character never waits on the output register
  assign s1_advance = s1_valid && (!s1_last || !out_valid || result_out.ready);
  assign char_in.ready = !s1_valid || s1_advance;

  assign step.advance   = s1_advance;
  assign step.last_char = s1_last;
  assign step.char_code = s1_char;

  cpf_digit_acc u_acc (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_in.ready) begin
      s1_valid <= char_in.valid;
    end
    if (char_in.ready) begin
      s1_char <= char_in.char_code;
      s1_last <= char_in.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_advance && s1_last) begin
      id_valid <= verdict;
    end
  end

  assign result_out.valid    = out_valid;
  assign result_out.id_valid = id_valid;

endmodule

// ----- rtl/cpf_checker.sv -----
`timescale 1ns / 1ps

module cpf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_id_valid
);

  // hold a stalled verdict
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_id_valid))
    else $error("result word changed while stalled");

  // a verdict entering an empty output register came from a final character
  // taken earlier (input register, then output register)
  a_rise_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("result word without a final character");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output is free");

endmodule

bind cpf_check_digit_validator cpf_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (char_in.valid),
  .in_ready     (char_in.ready),
  .in_last      (char_in.last_char),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .out_id_valid (result_out.id_valid)
);

// ----- bench/cpf_check_digit_validator_tb.sv -----
`timescale 1ns / 1ps

module cpf_check_digit_validator_tb;
  import cpf_pkg::*;

  typedef struct packed {
    logic [7:0] code;
    logic       is_last;
  } char_word_t;

  typedef enum int {
    SHAPE_GOOD,
    SHAPE_BAD_CHECK,
    SHAPE_BAD_LEN,
    SHAPE_BAD_SEPS,
    SHAPE_NOISE,
    SHAPE_STRAY_BYTE
  } id_shape_e;

  localparam int RANDOM_CHARS = 1400;
  localparam int TAIL_CHARS   = 150;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  logic clk = 1'b0;
  logic rst;

  cpf_char_if   char_in ();
  cpf_result_if result_out ();

  cpf_check_digit_validator u_dut (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .result_out(result_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  char_word_t chars_to_send[$];
  logic       verdicts_due[$];
  logic [7:0] id_text[$];

  // Running view of the ID being received.
  logic [3:0] seen_chars;
  logic [3:0] seen_digits;
  logic [1:0] seen_dots;
  logic [1:0] seen_hyphens;
  logic       seen_bad;
  logic [8:0] sum_first;
  logic [9:0] sum_second;
  logic [3:0] tenth;
  logic [3:0] eleventh;

  int faults        = 0;
  int ids_queued    = 0;
  int chars_queued  = 0;
  int verdicts_seen = 0;
  int valid_seen    = 0;

  int src_gap       = 0;
  int src_idle_pct  = 0;
  int src_span_left = 0;
  int snk_gap       = 0;
  int snk_idle_pct  = 0;
  int snk_span_left = 0;

  function automatic logic [3:0] mod11_check(input int unsigned wsum);
    int unsigned r;
    r = (wsum * 10) % 11;
    return (r == 10) ? 4'd0 : r[3:0];
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 4;
      2: return 15;
      default: return 35;
    endcase
  endfunction

  task automatic clear_id_state();
    seen_chars   = '0;
    seen_digits  = '0;
    seen_dots    = '0;
    seen_hyphens = '0;
    seen_bad     = 1'b0;
    sum_first    = '0;
    sum_second   = '0;
    tenth        = '0;
    eleventh     = '0;
  endtask

  // Fold one accepted character in; on the last one, queue the verdict and start over.
  task automatic fold_char(input char_word_t w);
    int  d;
    int  pos;
    logic shape_ok;
    if (seen_chars != COUNT_TOP) seen_chars = seen_chars + 4'd1;
    if (w.code >= ZERO_CODE && w.code <= NINE_CODE) begin
      d   = int'(w.code - ZERO_CODE);
      pos = int'(seen_digits);
      if (pos < int'(FIRST_SPAN)) sum_first = sum_first + 9'(d * (int'(FIRST_TOP_W) - pos));
      if (pos < int'(SECOND_SPAN)) begin
        sum_second = sum_second + 10'(d * (int'(SECOND_TOP_W) - pos));
      end
      if (pos == int'(FIRST_SPAN)) tenth = 4'(d);
      if (pos == int'(SECOND_SPAN)) eleventh = 4'(d);
      if (seen_digits != COUNT_TOP) seen_digits = seen_digits + 4'd1;
    end else if (w.code == DOT_CODE) begin
      if (seen_dots != SEP_TOP) seen_dots = seen_dots + 2'd1;
    end else if (w.code == HYPHEN_CODE) begin
      if (seen_hyphens != SEP_TOP) seen_hyphens = seen_hyphens + 2'd1;
    end else begin
      seen_bad = 1'b1;
    end

    if (w.is_last) begin
      if (seen_bad) begin
        shape_ok = 1'b0;
      end else if (seen_chars == PLAIN_LEN) begin
        shape_ok = (seen_digits == PLAIN_LEN);
      end else if (seen_chars == PUNCT_LEN) begin
        shape_ok = (seen_dots == DOTS_NEEDED) && (seen_hyphens == HYPH_NEEDED) &&
                   (seen_digits == PLAIN_LEN);
      end else begin
        shape_ok = 1'b0;
      end
      verdicts_due.push_back(shape_ok && (mod11_check(sum_first) == tenth) &&
                             (mod11_check(sum_second) == eleventh));
      clear_id_state();
    end
  endtask

  task automatic report_fault(input string what, input logic exp_v, input logic got_v);
    faults++;
    if (faults <= MAX_REPORTS) begin
      $display("%0t: %s: expected id_valid=%0b, got %0b", $time, what, exp_v, got_v);
    end
  endtask

  // Move id_text into the send queue, marking its final character.
  task automatic queue_id_text();
    char_word_t w;
    for (int i = 0; i < id_text.size(); i++) begin
      w.code    = id_text[i];
      w.is_last = (i == id_text.size() - 1);
      chars_to_send.push_back(w);
    end
    chars_queued += id_text.size();
    ids_queued++;
    id_text.delete();
  endtask

  task automatic queue_string(input string s);
    for (int i = 0; i < s.len(); i++) id_text.push_back(s[i]);
    queue_id_text();
  endtask

  // Fill id_text with a CPF whose check digits are computed, optionally broken.
  task automatic build_cpf(input bit punct, input bit scatter, input bit break_check);
    int dig[11];
    int s1;
    int s2;
    int k;
    int same;
    s1   = 0;
    s2   = 0;
    same = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      dig[i] = ($urandom_range(0, 7) == 0) ? same : $urandom_range(0, 9);
      s1 += dig[i] * (10 - i);
      s2 += dig[i] * (11 - i);
    end
    dig[9]  = mod11_check(s1);
    s2     += dig[9] * 2;
    dig[10] = mod11_check(s2);
    if (break_check) begin
      k      = $urandom_range(9, 10);
      dig[k] = (dig[k] + $urandom_range(1, 9)) % 10;
    end
    id_text.delete();
    for (int i = 0; i < 11; i++) begin
      id_text.push_back(ZERO_CODE + 8'(dig[i]));
      if (punct && !scatter && (i == 2 || i == 5)) id_text.push_back(DOT_CODE);
      if (punct && !scatter && i == 8) id_text.push_back(HYPHEN_CODE);
    end
    if (punct && scatter) begin
      id_text.insert($urandom_range(0, id_text.size()), DOT_CODE);
      id_text.insert($urandom_range(0, id_text.size()), DOT_CODE);
      id_text.insert($urandom_range(0, id_text.size()), HYPHEN_CODE);
    end
  endtask

  always @(posedge clk) begin : char_driver
    logic calm;
    if (rst) begin
      char_in.valid <= 1'b0;
    end else begin
      calm = (chars_to_send.size() < TAIL_CHARS);
      if (char_in.valid && char_in.ready) fold_char(chars_to_send.pop_front());
      if (src_span_left <= 0) begin
        src_idle_pct  = pick_idle_pct();
        src_span_left = $urandom_range(64, 256);
      end else begin
        src_span_left--;
      end
      if (calm) src_gap = 0;
      // Hold a word that has not been taken yet.
      if (!(char_in.valid && !char_in.ready)) begin
        if (src_gap > 0) begin
          src_gap--;
          char_in.valid <= 1'b0;
        end else if (!calm && $urandom_range(1, 100) <= src_idle_pct) begin
          src_gap = $urandom_range(0, 12);
          char_in.valid <= 1'b0;
        end else if (chars_to_send.size() > 0) begin
          char_in.valid     <= 1'b1;
          char_in.char_code <= chars_to_send[0].code;
          char_in.last_char <= chars_to_send[0].is_last;
        end else begin
          char_in.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    logic due;
    logic calm;
    if (rst) begin
      result_out.ready <= 1'b0;
    end else begin
      calm = (chars_to_send.size() < TAIL_CHARS);
      if (result_out.valid && result_out.ready) begin
        verdicts_seen++;
        if (verdicts_due.size() == 0) begin
          report_fault("verdict with none pending", 1'bx, result_out.id_valid);
        end else begin
          due = verdicts_due.pop_front();
          if (result_out.id_valid !== due) report_fault("verdict mismatch", due, result_out.id_valid);
          if (due) valid_seen++;
        end
      end
      if (snk_span_left <= 0) begin
        snk_idle_pct  = pick_idle_pct();
        snk_span_left = $urandom_range(64, 256);
      end else begin
        snk_span_left--;
      end
      if (calm) snk_gap = 0;
      if (snk_gap > 0) begin
        snk_gap--;
        result_out.ready <= 1'b0;
      end else if (!calm && $urandom_range(1, 100) <= snk_idle_pct) begin
        snk_gap = $urandom_range(0, 12);
        result_out.ready <= 1'b0;
      end else begin
        result_out.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    id_shape_e shape;
    int        pick;
    int        n;
    char_in.valid     = 1'b0;
    char_in.char_code = '0;
    char_in.last_char = 1'b0;
    result_out.ready  = 1'b0;
    rst               = 1'b1;
    clear_id_state();

    // Lone extreme bytes, then one known-good CPF in both forms.
    id_text.push_back(8'h00);
    queue_id_text();
    id_text.push_back(8'hFF);
    queue_id_text();
    queue_string("52998224725");
    queue_string("529.982.247-25");

    while (chars_queued < RANDOM_CHARS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) shape = SHAPE_GOOD;
      else if (pick < 60) shape = SHAPE_BAD_CHECK;
      else if (pick < 70) shape = SHAPE_BAD_LEN;
      else if (pick < 80) shape = SHAPE_BAD_SEPS;
      else if (pick < 90) shape = SHAPE_NOISE;
      else shape = SHAPE_STRAY_BYTE;

      case (shape)
        SHAPE_GOOD: begin
          build_cpf($urandom_range(0, 1), $urandom_range(0, 3) == 0, 1'b0);
        end
        SHAPE_BAD_CHECK: begin
          build_cpf($urandom_range(0, 1), $urandom_range(0, 3) == 0, 1'b1);
        end
        SHAPE_BAD_LEN: begin
          build_cpf($urandom_range(0, 1), 1'b0, 1'b0);
          if ($urandom_range(0, 1)) begin
            n = $urandom_range(1, 10);
            repeat (n) id_text.delete($urandom_range(0, id_text.size() - 1));
          end else begin
            n = $urandom_range(1, 8);
            repeat (n) id_text.push_back(ZERO_CODE + 8'($urandom_range(0, 9)));
          end
        end
        SHAPE_BAD_SEPS: begin
          build_cpf($urandom_range(0, 1), $urandom_range(0, 1), 1'b0);
          if ($urandom_range(0, 1)) begin
            id_text[$urandom_range(0, id_text.size() - 1)] =
              $urandom_range(0, 1) ? DOT_CODE : HYPHEN_CODE;
          end else begin
            // Pile up separators to drive their counts into saturation.
            n = $urandom_range(1, 6);
            repeat (n) id_text.insert($urandom_range(0, id_text.size()),
                                      $urandom_range(0, 1) ? DOT_CODE : HYPHEN_CODE);
          end
        end
        SHAPE_NOISE: begin
          n = $urandom_range(1, 18);
          repeat (n) id_text.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          build_cpf($urandom_range(0, 1), 1'b0, 1'b0);
          id_text[$urandom_range(0, id_text.size() - 1)] = 8'($urandom_range(0, 255));
        end
      endcase
      queue_id_text();
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (chars_to_send.size() != 0 || verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (verdicts_due.size() != 0) begin
      $display("%0d verdicts never arrived", verdicts_due.size());
      faults += verdicts_due.size();
    end

    $display("Covered %0d IDs in %0d characters: good, bad check, bad length, bad separators,",
             ids_queued, chars_queued);
    $display("stray bytes and noise; %0d verdicts checked, %0d of them valid CPFs",
             verdicts_seen, valid_seen);
    if (faults == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timeout waiting for the block to finish");
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cpf_pkg.sv
rtl/cpf_if.sv
rtl/cpf_digit_acc.sv
rtl/cpf_check_digit_validator.sv
rtl/cpf_checker.sv
bench/cpf_check_digit_validator_tb.sv
